@@ hdl/bfc_pkg.sv @@
package bfc_pkg;

  localparam int CoordWidthDefault = 16;
  localparam int DistWidth = 17;
  localparam int LodWidth = 8;
  localparam int IdWidth = 32;
  localparam int CfgDataWidth = 64;
  localparam int CfgIndexWidth = 3;
  localparam int SqWidth = 36;
  localparam int SqrtWidth = 18;
  localparam int CoefWidth = 17;
  localparam int NumPlanes = 6;
  localparam int QueueDepth = 32;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_ROW0 = 3'd0,
    CFG_ROW1 = 3'd1,
    CFG_ROW2 = 3'd2,
    CFG_ROW3 = 3'd3,
    CFG_OBSERVER = 3'd4,
    CFG_MAX_DIST = 3'd5,
    CFG_LOD_STEP = 3'd6,
    CFG_MAX_LOD = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [IdWidth-1:0] id;
    logic [DistWidth-1:0] distance;
  } front_item_t;

  typedef struct packed {
    logic [IdWidth-1:0] id;
    logic [LodWidth-1:0] lod;
    logic [DistWidth-1:0] distance;
  } result_t;

endpackage

@@ hdl/bfc_front.sv @@
module bfc_front
  import bfc_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [IdWidth-1:0] in_id,
  input  logic signed [COORD_WIDTH-1:0] bmin [3],
  input  logic signed [COORD_WIDTH-1:0] bmax [3],
  input  logic [63:0] rows [4],
  input  logic [47:0] observer,
  input  logic [DistWidth-1:0] max_distance,
  output logic out_valid,
  output front_item_t out_item
);

  localparam int GW = (COORD_WIDTH > 16 ? COORD_WIDTH : 16) + 3;
  localparam int PW = CoefWidth + COORD_WIDTH + 1;
  localparam int AW = PW + 3;
  localparam int NS = SqrtWidth;

  logic signed [CoefWidth-1:0] pl [NumPlanes][4];
  logic signed [PW-1:0] prod [NumPlanes][4];
  logic signed [AW-1:0] acc [NumPlanes];
  logic [NumPlanes-1:0] neg;
  logic [DistWidth:0] gcl [3];
  logic [SqWidth-1:0] sqa [3];

  logic v1;
  logic [IdWidth-1:0] id1;
  logic [SqWidth-1:0] sq1 [3];
  logic [NumPlanes-1:0] cull1;

  logic v2;
  logic [IdWidth-1:0] id2;
  logic [SqWidth+1:0] sum2;
  logic cull2;

  logic sv [NS+1];
  logic [IdWidth-1:0] sid [NS+1];
  logic cul [NS+1];
  logic [SqWidth+1:0] rem [NS+1];
  logic [SqrtWidth:0] root [NS+1];

  function automatic logic signed [CoefWidth-1:0] cf(input logic [63:0] r, input int c);
    return CoefWidth'($signed(r[16*c +: 16]));
  endfunction

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      pl[0][c] = cf(rows[3], c) + cf(rows[0], c);
      pl[1][c] = cf(rows[3], c) - cf(rows[0], c);
      pl[2][c] = cf(rows[3], c) + cf(rows[1], c);
      pl[3][c] = cf(rows[3], c) - cf(rows[1], c);
      pl[4][c] = cf(rows[2], c);
      pl[5][c] = cf(rows[3], c) - cf(rows[2], c);
    end
    for (int p = 0; p < NumPlanes; p++) begin
      for (int a = 0; a < 3; a++) begin
        prod[p][a] = PW'(pl[p][a]) * PW'(pl[p][a][CoefWidth-1] ? bmin[a] : bmax[a]);
      end
      prod[p][3] = PW'(pl[p][3]) <<< 4;
      acc[p] = AW'(prod[p][0]) + AW'(prod[p][1]) + AW'(prod[p][2]) + AW'(prod[p][3]);
      neg[p] = acc[p][AW-1];
    end
    for (int a = 0; a < 3; a++) begin
      logic signed [GW-1:0] o, g, h;
      o = GW'($signed(observer[16*a +: 16]));
      g = GW'(bmin[a]) - o;
      h = o - GW'(bmax[a]);
      if (g < 0) g = '0;
      if (h > g) g = h;
      if (g > GW'(131072)) gcl[a] = (DistWidth+1)'(131072);
      else gcl[a] = (DistWidth+1)'(g);
      sqa[a] = SqWidth'(gcl[a]) * SqWidth'(gcl[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
    id1 <= in_id;
    sq1 <= sqa;
    cull1 <= neg;
    id2 <= id1;
    sum2 <= (SqWidth+2)'(sq1[0]) + (SqWidth+2)'(sq1[1]) + (SqWidth+2)'(sq1[2]);
    cull2 <= |cull1;
  end

  assign sv[0] = v2;
  assign sid[0] = id2;
  assign cul[0] = cull2;
  assign rem[0] = sum2;
  assign root[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam int B = 2 * (NS - 1 - k);
    logic [SqWidth+1:0] trial;
    assign trial = (SqWidth+2)'({root[k], 2'b01}) << B;
    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else sv[k+1] <= sv[k];
      sid[k+1] <= sid[k];
      cul[k+1] <= cul[k];
      if (rem[k] >= trial) begin
        rem[k+1] <= rem[k] - trial;
        root[k+1] <= {root[k][SqrtWidth-1:0], 1'b1};
      end else begin
        rem[k+1] <= rem[k];
        root[k+1] <= {root[k][SqrtWidth-1:0], 1'b0};
      end
    end
  end

  logic far;
  assign far = (max_distance != '0) && (root[NS] > (SqrtWidth+1)'(max_distance));
  assign out_valid = sv[NS] && !cul[NS] && !far;
  assign out_item.id = sid[NS];
  assign out_item.distance = (root[NS] > (SqrtWidth+1)'(131071)) ? DistWidth'(131071)
                                                               : DistWidth'(root[NS]);

endmodule

@@ hdl/bfc_queue.sv @@
module bfc_queue
  import bfc_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  front_item_t wdata,
  input  logic rd,
  output logic nonempty,
  output front_item_t rdata,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  front_item_t mem [DEPTH];
  logic [AW-1:0] wp, rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      count <= count + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
    end
    if (wr) mem[wp] <= wdata;
  end

  assign nonempty = count != '0;
  assign rdata = mem[rp];

endmodule

@@ hdl/bfc_back.sv @@
module bfc_back
  import bfc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  front_item_t in_item,
  output logic in_take,
  input  logic [DistWidth-1:0] lod_step,
  input  logic [LodWidth-1:0] max_lod,
  output logic res_valid,
  output result_t res,
  input  logic res_take
);

  localparam int NQ = DistWidth;

  logic adv;
  logic v [NQ+1];
  logic [IdWidth-1:0] id [NQ+1];
  logic [DistWidth-1:0] d [NQ+1];
  logic [DistWidth-1:0] r [NQ+1];
  logic [DistWidth-1:0] q [NQ+1];
  logic [DistWidth:0] part [NQ+1];

  assign adv = !res_valid || res_take;
  assign in_take = in_valid && adv;

  assign v[0] = in_take;
  assign id[0] = in_item.id;
  assign d[0] = in_item.distance;
  assign r[0] = in_item.distance;
  assign q[0] = '0;
  assign part[0] = '0;

  for (genvar k = 0; k < NQ; k++) begin : g_div
    logic [DistWidth:0] pn;
    assign pn = {part[k][DistWidth-1:0], r[k][DistWidth-1]};
    always_ff @(posedge clk) begin
      if (rst) v[k+1] <= 1'b0;
      else if (adv) v[k+1] <= v[k];
      if (adv) begin
        id[k+1] <= id[k];
        d[k+1] <= d[k];
        r[k+1] <= {r[k][DistWidth-2:0], 1'b0};
        if (pn >= {1'b0, lod_step}) begin
          part[k+1] <= pn - {1'b0, lod_step};
          q[k+1] <= {q[k][DistWidth-2:0], 1'b1};
        end else begin
          part[k+1] <= pn;
          q[k+1] <= {q[k][DistWidth-2:0], 1'b0};
        end
      end
    end
  end

  logic [LodWidth-1:0] lod;
  always_comb begin
    if (lod_step == '0) lod = '0;
    else if (q[NQ] > DistWidth'(max_lod)) lod = max_lod;
    else lod = LodWidth'(q[NQ]);
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (adv) res_valid <= v[NQ];
    if (adv) begin
      res.id <= id[NQ];
      res.lod <= lod;
      res.distance <= d[NQ];
    end
  end

endmodule

@@ hdl/box_frustum_cull_with_lod.sv @@
// A pushed box passes the front pipeline into the front queue, then the LOD divider and its
// output register. Throughput: one item per cycle while full is low; the front pipeline
// (gap, square, 18-stage square root, plane tests) never stalls, the back divider pipeline
// stalls only when results are not popped.
// Reset: synchronous active-high rst clears the configuration registers, pipeline valids and the queue.
module box_frustum_cull_with_lod
  import bfc_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [IdWidth-1:0] box_id,
  input  logic signed [COORD_WIDTH-1:0] min_x,
  input  logic signed [COORD_WIDTH-1:0] min_y,
  input  logic signed [COORD_WIDTH-1:0] min_z,
  input  logic signed [COORD_WIDTH-1:0] max_x,
  input  logic signed [COORD_WIDTH-1:0] max_y,
  input  logic signed [COORD_WIDTH-1:0] max_z,
  output logic empty,
  input  logic pop,
  output logic [IdWidth-1:0] visible_id,
  output logic [LodWidth-1:0] lod_level,
  output logic [DistWidth-1:0] box_distance,
  input  logic cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  localparam int FrontLat = SqrtWidth + 2;
  localparam int QDepth = QueueDepth;
  localparam int CW = $clog2(QDepth + 1);
  localparam int FW = $clog2(FrontLat + 2);

  logic [63:0] rows [4];
  logic [47:0] observer;
  logic [DistWidth-1:0] max_distance, lod_step;
  logic [LodWidth-1:0] max_lod;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= '{default: '0};
      observer <= '0;
      max_distance <= '0;
      lod_step <= '0;
      max_lod <= '0;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_ROW0: rows[0] <= cfg_data;
        CFG_ROW1: rows[1] <= cfg_data;
        CFG_ROW2: rows[2] <= cfg_data;
        CFG_ROW3: rows[3] <= cfg_data;
        CFG_OBSERVER: observer <= cfg_data[47:0];
        CFG_MAX_DIST: max_distance <= cfg_data[DistWidth-1:0];
        CFG_LOD_STEP: lod_step <= cfg_data[DistWidth-1:0];
        CFG_MAX_LOD: max_lod <= cfg_data[LodWidth-1:0];
        default: ;
      endcase
    end
  end

  logic accept;
  logic signed [COORD_WIDTH-1:0] bmin [3], bmax [3];
  logic f_valid, q_ne, q_take;
  front_item_t f_item, q_item;
  logic [CW-1:0] q_count;
  logic [FW-1:0] inflight;
  result_t res;

  assign accept = push && !full;
  assign bmin = '{min_x, min_y, min_z};
  assign bmax = '{max_x, max_y, max_z};

  bfc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst, .in_valid(accept), .in_id(box_id), .bmin, .bmax, .rows, .observer,
    .max_distance, .out_valid(f_valid), .out_item(f_item)
  );

  // count items inside the front pipeline so the queue cannot overflow
  logic [FrontLat-1:0] track;
  always_ff @(posedge clk) begin
    if (rst) track <= '0;
    else track <= {track[FrontLat-2:0], accept};
  end
  always_comb begin
    inflight = '0;
    for (int i = 0; i < FrontLat; i++) inflight = inflight + FW'(track[i]);
  end
  assign full = (CW+1)'(q_count) + (CW+1)'(inflight) >= (CW+1)'(QDepth - 1);

  bfc_queue #(.DEPTH(QDepth)) u_queue (
    .clk, .rst, .wr(f_valid), .wdata(f_item), .rd(q_take), .nonempty(q_ne),
    .rdata(q_item), .count(q_count)
  );

  logic res_valid;
  bfc_back u_back (
    .clk, .rst, .in_valid(q_ne), .in_item(q_item), .in_take(q_take), .lod_step,
    .max_lod, .res_valid, .res, .res_take(pop && res_valid)
  );

  assign empty = !res_valid;
  assign visible_id = res.id;
  assign lod_level = res.lod;
  assign box_distance = res.distance;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(f_valid && !q_take && q_count == CW'(QDepth))) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_count != '0) else $error("queue underflow");
  a_front_from_accept: assert property (@(posedge clk) disable iff (rst)
    f_valid |-> track[FrontLat-1]) else $error("front result without item");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bfc_pkg::*;

  localparam int CW = CoordWidthDefault;
  localparam int DrainCycles = 80;

  typedef struct {
    logic [IdWidth-1:0] id;
    logic signed [CW-1:0] mn[3];
    logic signed [CW-1:0] mx[3];
    bit known;
    bit vis;
    result_t res;
  } box_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [IdWidth-1:0] box_id = '0;
  logic signed [CW-1:0] min_x = '0, min_y = '0, min_z = '0;
  logic signed [CW-1:0] max_x = '0, max_y = '0, max_z = '0;
  logic empty;
  logic pop = 1'b0;
  logic [IdWidth-1:0] visible_id;
  logic [LodWidth-1:0] lod_level;
  logic [DistWidth-1:0] box_distance;
  logic cfg_write = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  logic [63:0] mrow[4];
  logic [47:0] obs_pos;
  logic [16:0] dist_limit;
  logic [16:0] lod_div;
  logic [7:0] lod_cap;

  result_t visible_q[$];
  int errors = 0;
  int pop_hold = 0;
  bit stim_done = 1'b0;
  box_row_t dir_rows[$];

  box_frustum_cull_with_lod u_top (.*);

  always #5 clk = ~clk;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint isqrt(input longint x);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint coef(input int r, input int c);
    logic signed [15:0] v;
    v = mrow[r][16*c +: 16];
    return longint'(v);
  endfunction

  function automatic bit cull_box(input box_row_t b, output result_t res);
    longint sq, g, h, o, d, acc, rep, lod;
    longint pl[4];
    logic signed [15:0] ov;
    sq = 0;
    for (int a = 0; a < 3; a++) begin
      ov = obs_pos[16*a +: 16];
      o = longint'(ov);
      g = longint'(b.mn[a]) - o;
      h = o - longint'(b.mx[a]);
      if (g < 0) g = 0;
      if (h > g) g = h;
      if (g > 131072) g = 131072;
      sq += g * g;
    end
    d = isqrt(sq);
    if (dist_limit != 0 && d > longint'(dist_limit)) return 1'b0;
    for (int p = 0; p < NumPlanes; p++) begin
      for (int c = 0; c < 4; c++) begin
        case (p)
          0: pl[c] = coef(3, c) + coef(0, c);
          1: pl[c] = coef(3, c) - coef(0, c);
          2: pl[c] = coef(3, c) + coef(1, c);
          3: pl[c] = coef(3, c) - coef(1, c);
          4: pl[c] = coef(2, c);
          default: pl[c] = coef(3, c) - coef(2, c);
        endcase
      end
      acc = pl[3] * 16;
      for (int a = 0; a < 3; a++)
        acc += pl[a] * (pl[a] >= 0 ? longint'(b.mx[a]) : longint'(b.mn[a]));
      if (acc < 0) return 1'b0;
    end
    rep = d > 131071 ? 131071 : d;
    if (lod_div == 0) begin
      lod = 0;
    end else begin
      lod = rep / longint'(lod_div);
      if (lod > longint'(lod_cap)) lod = lod_cap;
    end
    res.id = b.id;
    res.lod = lod[7:0];
    res.distance = rep[16:0];
    return 1'b1;
  endfunction

  task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_ROW0: mrow[0] = val;
      CFG_ROW1: mrow[1] = val;
      CFG_ROW2: mrow[2] = val;
      CFG_ROW3: mrow[3] = val;
      CFG_OBSERVER: obs_pos = val[47:0];
      CFG_MAX_DIST: dist_limit = val[16:0];
      CFG_LOD_STEP: lod_div = val[16:0];
      default: lod_cap = val[7:0];
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain;
    while (visible_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [15:0] short_gap(input int m);
    return 16'($urandom_range(m, 0));
  endfunction

  task automatic send_box(input box_row_t b);
    result_t r;
    int gap;
    bit vis;
    gap = ($urandom_range(9, 0) < 6) ? 0 :
          ($urandom_range(19, 0) == 0 ? $urandom_range(40, 5) : $urandom_range(3, 1));
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    box_id <= b.id;
    min_x <= b.mn[0];
    min_y <= b.mn[1];
    min_z <= b.mn[2];
    max_x <= b.mx[0];
    max_y <= b.mx[1];
    max_z <= b.mx[2];
    @(posedge clk);
    while (full) @(posedge clk);
    vis = cull_box(b, r);
    if (b.known) begin
      if (vis != b.vis) begin
        report("directed visibility", vis, b.vis);
      end else if (vis) begin
        if (r.lod != b.res.lod) report("directed lod_level", r.lod, b.res.lod);
        if (r.distance != b.res.distance)
          report("directed box_distance", r.distance, b.res.distance);
      end
    end
    if (vis) visible_q = {visible_q, r};
  endtask

  function automatic logic [63:0] rand_row(input int mode);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case (mode)
      0: v = v & 64'h03FF_03FF_03FF_03FF;
      1: v = v;
      default: v = v & 64'h0000_00FF_00FF_00FF;
    endcase
    return v;
  endfunction

  task automatic rand_config(input int phase);
    write_reg(CFG_ROW0, {16'h0000, 16'h0000, 16'h0000, 16'h0100});
    write_reg(CFG_ROW1, {16'h0000, 16'h0000, 16'h0100, 16'h0000});
    write_reg(CFG_ROW2, {16'h0000, 16'h0100, 16'h0000, 16'h0000});
    write_reg(CFG_ROW3, {16'h7F00, 16'h0000, 16'h0000, 16'h0000});
    if (phase % 3 == 1) begin
      write_reg(CFG_ROW0, rand_row(0));
      write_reg(CFG_ROW1, rand_row(0));
      write_reg(CFG_ROW2, rand_row(0));
      write_reg(CFG_ROW3, rand_row(0) | 64'h4000_0000_0000_0000);
    end else if (phase % 3 == 2) begin
      write_reg(CFG_ROW0, rand_row(1));
      write_reg(CFG_ROW2, rand_row(2));
    end
    write_reg(CFG_OBSERVER, {$urandom, $urandom});
    case (phase % 4)
      0: write_reg(CFG_MAX_DIST, 0);
      1: write_reg(CFG_MAX_DIST, 17'h1FFFF);
      default: write_reg(CFG_MAX_DIST, $urandom_range(131071, 1));
    endcase
    case (phase % 5)
      0: write_reg(CFG_LOD_STEP, 0);
      1: write_reg(CFG_LOD_STEP, 1);
      2: write_reg(CFG_LOD_STEP, 17'h1FFFF);
      default: write_reg(CFG_LOD_STEP, $urandom_range(4000, 1));
    endcase
    write_reg(CFG_MAX_LOD, (phase % 3 == 0) ? 8'hFF : 8'($urandom_range(255, 0)));
  endtask

  function automatic box_row_t rand_box;
    box_row_t b;
    logic [15:0] o, s;
    b.id = $urandom;
    b.known = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if ($urandom_range(9, 0) < 2) begin
        b.mn[a] = 16'($urandom);
        b.mx[a] = 16'($urandom);
      end else begin
        o = obs_pos[16*a +: 16];
        s = $urandom_range(3, 0) == 0 ? 16'($urandom) : 16'($urandom_range(2000, 0));
        b.mn[a] = o + short_gap(4000) - 16'd2000;
        b.mx[a] = b.mn[a] + (s & 16'h0FFF);
      end
    end
    return b;
  endfunction

  function automatic box_row_t mk(input logic [31:0] id, input int lo, input int hi,
                                  input bit known, input bit vis, input int lod,
                                  input int d);
    box_row_t b;
    b.id = id;
    for (int a = 0; a < 3; a++) begin
      b.mn[a] = 16'(lo);
      b.mx[a] = 16'(hi);
    end
    b.known = known;
    b.vis = vis;
    b.res.id = id;
    b.res.lod = 8'(lod);
    b.res.distance = 17'(d);
    return b;
  endfunction

  initial begin
    for (int i = 0; i < 4; i++) mrow[i] = '0;
    obs_pos = '0;
    dist_limit = '0;
    lod_div = '0;
    lod_cap = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // all-zero planes pass, observer at origin
    dir_rows = {dir_rows, mk(32'h0, 0, 0, 1, 1, 0, 0)};
    dir_rows = {dir_rows, mk(32'hFFFF_FFFF, -32768, 32767, 1, 1, 0, 0)};
    dir_rows = {dir_rows, mk(32'h1, 32767, 32767, 1, 1, 0, 56754)};
    dir_rows = {dir_rows, mk(32'h2, -32768, -32768, 1, 1, 0, 56755)};
    dir_rows = {dir_rows, mk(32'h3, 100, -100, 1, 1, 0, 173)};
    dir_rows = {dir_rows, mk(32'h4, 16, 32, 1, 1, 0, 27)};
    foreach (dir_rows[i]) send_box(dir_rows[i]);
    push <= 1'b0;
    drain();
    write_reg(CFG_LOD_STEP, 16);
    write_reg(CFG_MAX_LOD, 8'hFF);
    write_reg(CFG_MAX_DIST, 100);
    dir_rows.delete();
    dir_rows = {dir_rows, mk(32'h10, 16, 32, 1, 1, 1, 27)};
    dir_rows = {dir_rows, mk(32'h11, 100, 200, 1, 0, 0, 0)};
    dir_rows = {dir_rows, mk(32'h12, 32767, 32767, 1, 0, 0, 0)};
    dir_rows = {dir_rows, mk(32'h13, -10, 10, 1, 1, 0, 0)};
    foreach (dir_rows[i]) send_box(dir_rows[i]);
    push <= 1'b0;
    drain();
    write_reg(CFG_MAX_DIST, 0);
    write_reg(CFG_MAX_LOD, 2);
    write_reg(CFG_ROW3, 64'h8000_8000_8000_8000);
    write_reg(CFG_OBSERVER, 48'h8000_7FFF_8000);
    dir_rows.delete();
    dir_rows = {dir_rows, mk(32'h20, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(32'h21, 32767, -32768, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(32'h22, -32768, -32768, 0, 0, 0, 0)};
    write_reg(CFG_ROW3, 64'h7FFF_7FFF_7FFF_7FFF);
    foreach (dir_rows[i]) send_box(dir_rows[i]);
    push <= 1'b0;
    drain();
    for (int ph = 0; ph < 15; ph++) begin
      rand_config(ph);
      for (int n = 0; n < 90; n++) send_box(rand_box());
      push <= 1'b0;
      drain();
    end
    stim_done = 1'b1;
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_hold <= 0;
    end else begin
      if (pop && !empty) begin
        if (visible_q.size() == 0) begin
          report("unexpected item", visible_id, 0);
        end else begin
          if (visible_id !== visible_q[0].id) report("visible_id", visible_id, visible_q[0].id);
          if (lod_level !== visible_q[0].lod) report("lod_level", lod_level, visible_q[0].lod);
          if (box_distance !== visible_q[0].distance)
            report("box_distance", box_distance, visible_q[0].distance);
          void'(visible_q.pop_front());
        end
      end
      if (pop_hold > 0) begin
        pop_hold <= pop_hold - 1;
        pop <= 1'b0;
      end else if ($urandom_range(49, 0) == 0) begin
        pop_hold <= $urandom_range(40, 5);
        pop <= 1'b0;
      end else begin
        pop <= $urandom_range(9, 0) < 7;
      end
    end
  end

  initial begin
    wait (stim_done);
    if (errors == 0 && visible_q.size() == 0) begin
      $display("PASS box_frustum_cull_with_lod");
    end else begin
      $display("FAIL box_frustum_cull_with_lod");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL box_frustum_cull_with_lod");
    $finish;
  end

endmodule
